### design/tflr_pkg.sv
// shared types and constants of the triangle filter line resampler
package tflr_pkg;

    // input function codes
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_COMPUTE = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_SCALE  = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;

    // fixed point constants
    localparam int Q16_ONE    = 65536;
    localparam int Q16_HALF   = 32768;
    localparam int SCALE_UNIT = 256;

    // shared divider: dividend bits and quotient width
    localparam int DIV_NB = 36;
    // normalize divider quotient bits
    localparam int NORM_QB = 9;
    // weight width in Q.16
    localparam int WW = 17;

    // sequencer states
    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_DIVR = 10'b00_0000_0010,
        S_DIVC = 10'b00_0000_0100,
        S_SPAN = 10'b00_0000_1000,
        S_TAP  = 10'b00_0001_0000,
        S_WDIV = 10'b00_0010_0000,
        S_ACC  = 10'b00_0100_0000,
        S_NSET = 10'b00_1000_0000,
        S_NORM = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } t_state;

endpackage

### design/tflr_ram.sv
// generic single write port, single read port ram with registered read
module tflr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/triangle_filter_line_resampler_core.sv
// triangle filter scanline resampler: line store in ram, sequential tap walk
// load request: no result; compute request: centre divide (after a radius divide
//   when downscaling), tap span, per tap a read and accumulate, with a weight divide
//   in between when downscaling, then normalize; taps <= 2*MAX_RADIUS+1
// one request at a time; the next request is taken once the result register is free
// synchronous active-low reset clears control, presets config; line store is not cleared
module triangle_filter_line_resampler_core import tflr_pkg::*; #(
    parameter int LINE_MAX   = 4096,
    parameter int MAX_RADIUS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // index[11:0], in_red, in_green, in_blue, zero pad
    input  logic        i_s_tuser,   // func
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // out_red, out_green, out_blue
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int AW        = $clog2(LINE_MAX);
    localparam int SCALE_MIN = (SCALE_UNIT + MAX_RADIUS - 1) / MAX_RADIUS;
    localparam int RMAX      = (1 << 24) / SCALE_MIN;
    localparam int RW        = $clog2(RMAX + 1);
    localparam int VW        = 2 * RW;
    localparam int CW        = 38;
    localparam int IW        = CW - 16;
    localparam int WSW       = WW + $clog2(2 * MAX_RADIUS + 2);
    localparam int ACW       = WSW + 8;
    localparam int NW        = ACW + 1;

    t_state r_state, n_state;

    logic [15:0] r_scale;
    logic [12:0] r_len;
    logic [15:0] r_s;
    logic        r_up;
    logic [12:0] r_llen;
    logic [11:0] r_idx;

    logic [RW-1:0]     r_rad;
    logic [VW-1:0]     r_r2;
    logic signed [CW-1:0] r_cen;
    logic signed [IW-1:0] r_i;
    logic signed [IW-1:0] r_right;
    logic [WW-1:0]     r_w;
    logic [WSW-1:0]    r_wsum;
    logic [ACW-1:0]    r_acc  [3];

    logic [VW-1:0]     r_rem;
    logic [DIV_NB-1:0] r_nsh;
    logic [DIV_NB-1:0] r_q;
    logic [5:0]        r_cnt;

    logic [WSW-1:0]     r_nrem [3];
    logic [NORM_QB-1:0] r_nlow [3];
    logic [NORM_QB-1:0] r_nq   [3];

    logic        r_ovalid;
    logic [23:0] r_odata;

    // input fields
    logic        in_func;
    logic [11:0] in_idx;
    logic [23:0] in_pix;
    logic        in_acc;
    assign in_func = i_s_tuser;
    assign in_idx  = i_s_tdata[11:0];
    assign in_pix  = i_s_tdata[35:12];
    assign in_acc  = i_s_tvalid && o_s_tready;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;

    // clamped registers
    logic [15:0] s_clamp;
    logic [12:0] len_clamp;
    assign s_clamp = (r_scale < 16'(SCALE_MIN)) ? 16'(SCALE_MIN) : r_scale;
    always_comb begin
        if (r_len == 13'd0) begin
            len_clamp = 13'd1;
        end else if (32'(r_len) > LINE_MAX) begin
            len_clamp = 13'(LINE_MAX);
        end else begin
            len_clamp = r_len;
        end
    end

    // shared restoring divider step
    logic [VW-1:0] div_v;
    logic [VW:0]   div_sh;
    logic          div_ge;
    logic [VW-1:0] div_rem_n;
    logic [DIV_NB-1:0] div_q_n;
    assign div_v     = (r_state == S_WDIV) ? r_r2 : VW'(r_s);
    assign div_sh    = {r_rem, r_nsh[DIV_NB-1]};
    assign div_ge    = div_sh >= {1'b0, div_v};
    assign div_rem_n = div_ge ? VW'(div_sh - {1'b0, div_v}) : div_sh[VW-1:0];
    assign div_q_n   = {r_q[DIV_NB-2:0], div_ge};

    // centre dividend setup
    logic [11:0]       set_idx;
    logic [DIV_NB-1:0] cnum;
    assign set_idx = (r_state == S_IDLE) ? in_idx : r_idx;
    assign cnum    = {set_idx, 1'b1, 23'd0};

    // tap span
    logic signed [CW-1:0] lo_sum, hi_sum;
    assign lo_sum = r_cen - $signed(CW'(r_rad)) + $signed(CW'(Q16_ONE - 1));
    assign hi_sum = r_cen + $signed(CW'(r_rad));

    // tap distance and clamped address
    logic signed [CW-1:0] tap_pos, tap_d;
    logic [RW-1:0]        d_q;
    logic signed [IW-1:0] llen_s;
    logic [AW-1:0]        tap_addr;
    assign tap_pos = $signed({r_i, 16'd0});
    assign tap_d   = tap_pos - r_cen;
    assign d_q     = tap_d[CW-1] ? RW'(-tap_d) : RW'(tap_d);
    assign llen_s  = $signed(IW'(r_llen));
    always_comb begin
        if (r_i < 0) begin
            tap_addr = '0;
        end else if (r_i >= llen_s) begin
            tap_addr = AW'(r_llen - 13'd1);
        end else begin
            tap_addr = AW'(r_i);
        end
    end

    // line store
    logic          ram_we, ram_re;
    logic [23:0]   ram_rdata;
    assign ram_we = in_acc && (in_func == FUNC_LOAD) && (32'(in_idx) < LINE_MAX);
    assign ram_re = (r_state == S_TAP);

    tflr_ram #(
        .WIDTH (24),
        .DEPTH (LINE_MAX)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(in_idx)),
        .i_wdata (in_pix),
        .i_re    (ram_re),
        .i_raddr (tap_addr),
        .o_rdata (ram_rdata)
    );

    // normalize step per channel
    logic [NW-1:0]      nset_n  [3];
    logic [WSW:0]       norm_sh [3];
    logic               norm_ge [3];
    logic [NORM_QB-1:0] out_ch  [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            nset_n[c]  = NW'(r_acc[c]) + NW'(r_wsum >> 1);
            norm_sh[c] = {r_nrem[c], r_nlow[c][NORM_QB-1]};
            norm_ge[c] = norm_sh[c] >= {1'b0, r_wsum};
            if (r_wsum == '0) begin
                out_ch[c] = '0;
            end else if (r_nq[c] > NORM_QB'(255)) begin
                out_ch[c] = NORM_QB'(255);
            end else begin
                out_ch[c] = r_nq[c];
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (in_func == FUNC_COMPUTE)) begin
                    n_state = (s_clamp > 16'(SCALE_UNIT)) ? S_DIVC : S_DIVR;
                end
            end
            S_DIVR: if (r_cnt == '0) n_state = S_DIVC;
            S_DIVC: if (r_cnt == '0) n_state = S_SPAN;
            S_SPAN: n_state = S_TAP;
            S_TAP:  n_state = r_up ? S_ACC : S_WDIV;
            S_WDIV: if (r_cnt == '0) n_state = S_ACC;
            S_ACC:  n_state = (r_i == r_right) ? S_NSET : S_TAP;
            S_NSET: n_state = S_NORM;
            S_NORM: if (r_cnt == '0) n_state = S_DONE;
            S_DONE: if (!r_ovalid || i_m_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_scale  <= 16'(SCALE_UNIT);
            r_len    <= 13'd4096;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_SCALE) begin
                    r_scale <= i_cfg_data;
                end else if (i_cfg_index == REG_LENGTH) begin
                    r_len <= i_cfg_data[12:0];
                end
            end
            if ((r_state == S_DONE) && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_r2 <= VW'(r_rad * r_rad);
        case (r_state)
            S_IDLE: begin
                r_s    <= s_clamp;
                r_up   <= s_clamp > 16'(SCALE_UNIT);
                r_llen <= len_clamp;
                r_idx  <= in_idx;
                r_wsum <= '0;
                for (int c = 0; c < 3; c++) r_acc[c] <= '0;
                r_rem  <= '0;
                r_q    <= '0;
                if (s_clamp > 16'(SCALE_UNIT)) begin
                    r_rad <= RW'(Q16_ONE);
                    r_nsh <= cnum;
                    r_cnt <= 6'(DIV_NB - 1);
                end else begin
                    r_nsh <= {1'b1, {(DIV_NB - 1){1'b0}}};
                    r_cnt <= 6'd24;
                end
            end
            S_DIVR: begin
                if (r_cnt == '0) begin
                    r_rad <= RW'(div_q_n);
                    r_rem <= '0;
                    r_q   <= '0;
                    r_nsh <= cnum;
                    r_cnt <= 6'(DIV_NB - 1);
                end else begin
                    r_rem <= div_rem_n;
                    r_q   <= div_q_n;
                    r_nsh <= r_nsh << 1;
                    r_cnt <= r_cnt - 6'd1;
                end
            end
            S_DIVC: begin
                r_rem <= div_rem_n;
                r_q   <= div_q_n;
                r_nsh <= r_nsh << 1;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    r_cen <= $signed({2'b00, div_q_n}) - $signed(CW'(Q16_HALF));
                end
            end
            S_SPAN: begin
                r_i     <= IW'(lo_sum >>> 16);
                r_right <= IW'(hi_sum >>> 16);
            end
            S_TAP: begin
                // upscale weight directly, downscale starts the weight divide
                r_w   <= WW'(Q16_ONE - 32'(d_q));
                r_rem <= VW'({r_rad - d_q, 15'd0});
                r_nsh <= '0;
                r_q   <= '0;
                r_cnt <= 6'(WW - 1);
            end
            S_WDIV: begin
                r_rem <= div_rem_n;
                r_q   <= div_q_n;
                r_nsh <= r_nsh << 1;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    r_w <= WW'(div_q_n);
                end
            end
            S_ACC: begin
                r_wsum <= r_wsum + WSW'(r_w);
                for (int c = 0; c < 3; c++) begin
                    r_acc[c] <= r_acc[c] + ACW'(r_w * ram_rdata[8*c +: 8]);
                end
                r_i <= r_i + IW'(1);
            end
            S_NSET: begin
                for (int c = 0; c < 3; c++) begin
                    r_nrem[c] <= WSW'(nset_n[c] >> NORM_QB);
                    r_nlow[c] <= nset_n[c][NORM_QB-1:0];
                    r_nq[c]   <= '0;
                end
                r_cnt <= 6'(NORM_QB - 1);
            end
            S_NORM: begin
                for (int c = 0; c < 3; c++) begin
                    r_nrem[c] <= norm_ge[c] ? WSW'(norm_sh[c] - {1'b0, r_wsum})
                                            : norm_sh[c][WSW-1:0];
                    r_nlow[c] <= r_nlow[c] << 1;
                    r_nq[c]   <= {r_nq[c][NORM_QB-2:0], norm_ge[c]};
                end
                r_cnt <= r_cnt - 6'd1;
            end
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    r_odata <= {out_ch[2][7:0], out_ch[1][7:0], out_ch[0][7:0]};
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

endmodule

### sim/triangle_filter_line_resampler_core_tb.sv
// self-checking testbench of the triangle filter line resampler core
module triangle_filter_line_resampler_core_tb import tflr_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH = 4096;
    localparam int SCALE_FLOOR = (SCALE_UNIT + 16 - 1) / 16;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic        func;
        logic [11:0] idx;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_pixel_req;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    triangle_filter_line_resampler_core i_dut (.*);

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state and stimulus bookkeeping
    logic [23:0] line_mem [LINE_DEPTH];
    bit          loaded [LINE_DEPTH];
    logic [15:0] scale_reg = 16'd256;
    logic [12:0] length_reg = 13'd4096;
    t_pixel_req  pending_reqs [$];
    t_rgb        filtered_q [$];
    bit          steady = 1'b0;
    int          error_cnt = 0;
    int          n_loads = 0, n_computes = 0, n_results = 0, n_cfg = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_cnt++;
    endtask

    // effective scale, radius, centre, tap span and clamped length of one output pixel
    function automatic void tap_span(input logic [11:0] idx, output bit up,
                                     output longint rad, output longint ctr,
                                     output longint lft, output longint rgt,
                                     output longint len);
        longint s;
        s = scale_reg;
        if (s < SCALE_FLOOR) s = SCALE_FLOOR;
        len = length_reg;
        if (len < 1) len = 1;
        if (len > LINE_DEPTH) len = LINE_DEPTH;
        up = s > SCALE_UNIT;
        rad = up ? Q16_ONE : (longint'(1) << 24) / s;
        ctr = ((2 * longint'(idx) + 1) << 23) / s - Q16_HALF;
        lft = -((rad - ctr) >>> 16);
        rgt = (ctr + rad) >>> 16;
    endfunction

    // weighted, normalized, rounded and saturated channel averages
    function automatic t_rgb filter_pixel(input logic [11:0] idx);
        bit up;
        longint rad, ctr, lft, rgt, len, d, p;
        longint unsigned w, wsum, ar, ag, ab, v;
        logic [23:0] px;
        t_rgb res;
        tap_span(idx, up, rad, ctr, lft, rgt, len);
        wsum = 0; ar = 0; ag = 0; ab = 0;
        for (longint i = lft; i <= rgt; i++) begin
            d = i * Q16_ONE - ctr;
            if (d < 0) d = -d;
            if (d > rad) continue;
            if (up) w = Q16_ONE - d;
            else w = (longint'(rad - d) << 32) / (rad * rad);
            p = (i < 0) ? 0 : (i >= len) ? len - 1 : i;
            px = line_mem[p];
            wsum += w;
            ar += w * px[7:0];
            ag += w * px[15:8];
            ab += w * px[23:16];
        end
        if (wsum == 0) return '{8'd0, 8'd0, 8'd0};
        v = (ar + wsum / 2) / wsum; res.red   = (v > 255) ? 8'd255 : v[7:0];
        v = (ag + wsum / 2) / wsum; res.green = (v > 255) ? 8'd255 : v[7:0];
        v = (ab + wsum / 2) / wsum; res.blue  = (v > 255) ? 8'd255 : v[7:0];
        return res;
    endfunction

    // sender: one request per handshake, random gaps unless steady
    always @(posedge i_clk) begin
        t_pixel_req req;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                if (i_s_tuser == FUNC_LOAD) begin
                    line_mem[i_s_tdata[11:0]] <= i_s_tdata[35:12];
                    n_loads++;
                end else begin
                    filtered_q.insert(filtered_q.size(), filter_pixel(i_s_tdata[11:0]));
                    n_computes++;
                end
            end
            if ((!i_s_tvalid || o_s_tready) && pending_reqs.size() > 0 &&
                (steady || $urandom_range(99) >= 33)) begin
                req = pending_reqs.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= req.func;
                i_s_tdata  <= {4'd0, req.blue, req.green, req.red, req.idx};
            end else if (!i_s_tvalid || o_s_tready) begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls unless steady, one long hold-off after the 40th result
    always @(posedge i_clk) begin
        int hold_cnt;
        t_rgb exp_px;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                n_results++;
                if (filtered_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", o_m_tdata));
                end else begin
                    exp_px = filtered_q.pop_front();
                    if (o_m_tdata[7:0] !== exp_px.red)
                        report_mismatch($sformatf("red %h, expected %h",
                                                  o_m_tdata[7:0], exp_px.red));
                    if (o_m_tdata[15:8] !== exp_px.green)
                        report_mismatch($sformatf("green %h, expected %h",
                                                  o_m_tdata[15:8], exp_px.green));
                    if (o_m_tdata[23:16] !== exp_px.blue)
                        report_mismatch($sformatf("blue %h, expected %h",
                                                  o_m_tdata[23:16], exp_px.blue));
                end
                if (n_results == 40) hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= steady || ($urandom_range(99) >= 33);
            end
        end
    end

    task automatic push_load(input logic [11:0] idx, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
        pending_reqs.insert(pending_reqs.size(), '{FUNC_LOAD, idx, r, g, b});
        loaded[idx] = 1'b1;
    endtask

    // compute request, preceded by loads of any unwritten entry it reads
    task automatic push_compute(input logic [11:0] idx);
        bit up;
        longint rad, ctr, lft, rgt, len;
        tap_span(idx, up, rad, ctr, lft, rgt, len);
        if (lft < 0) lft = 0;
        if (rgt > len - 1) rgt = len - 1;
        if (lft > len - 1) lft = len - 1;
        for (longint i = lft; i <= rgt; i++)
            if (!loaded[i]) push_load(12'(i), 8'($urandom), 8'($urandom), 8'($urandom));
        pending_reqs.insert(pending_reqs.size(),
                            '{FUNC_COMPUTE, idx, 8'($urandom), 8'($urandom), 8'($urandom)});
    endtask

    // wait until the block has drained every request and result
    task automatic wait_idle();
        do begin
            @(posedge i_clk); #1;
        end while (pending_reqs.size() > 0 || i_s_tvalid || filtered_q.size() > 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_SCALE) scale_reg = data;
        else if (idx == REG_LENGTH) length_reg = data[12:0];
        n_cfg++;
    endtask

    // random requests, loads mostly inside the valid line
    task automatic random_phase(input int count);
        int lim;
        lim = (length_reg == 0) ? 1 : (length_reg > LINE_DEPTH) ? LINE_DEPTH : length_reg;
        repeat (count) begin
            if ($urandom_range(99) < 40) begin
                if ($urandom_range(3) == 0)
                    push_load(12'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                else
                    push_load(12'($urandom_range(lim - 1)), 8'($urandom), 8'($urandom),
                              8'($urandom));
            end else begin
                push_compute(12'($urandom));
            end
        end
    endtask

    // stimulus
    initial begin
        logic [15:0] scales [11];
        logic [15:0] lens [11];
        scales = '{16'd65535, 16'd16, 16'd0, 16'd257, 16'd256, 16'd255,
                   16'd15, 16'd0, 16'd0, 16'd0, 16'd0};
        lens = '{16'd1, 16'd4096, 16'd0, 16'hE025, 16'd8191, 16'd200,
                 16'd64, 16'd0, 16'd0, 16'd0, 16'd0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme pixels and positions under reset settings
        push_load(12'd0, 8'd0, 8'd0, 8'd0);
        push_load(12'd1, 8'd255, 8'd255, 8'd255);
        push_load(12'd4095, 8'd255, 8'd0, 8'd255);
        push_load(12'd4094, 8'd1, 8'd2, 8'd3);
        push_load(12'd2, 8'd128, 8'd127, 8'd1);
        push_compute(12'd0);
        push_compute(12'd1);
        push_compute(12'd4095);
        push_compute(12'd4094);
        push_compute(12'd2);
        push_load(12'd1, 8'd0, 8'd255, 8'd0);
        push_compute(12'd1);
        push_load(12'hAAA, 8'h55, 8'hAA, 8'h55);
        push_load(12'h555, 8'hAA, 8'h55, 8'hAA);
        push_compute(12'hAAA);
        push_compute(12'h555);
        wait_idle();

        for (int ph = 0; ph < 11; ph++) begin
            if (ph >= 7) begin
                scales[ph] = 16'($urandom_range(SCALE_FLOOR + 8, 16'hFFFF));
                lens[ph] = {3'($urandom_range(7)), 1'b0, 12'd0} |
                           16'($urandom_range(1, 300));
            end
            cfg_write(REG_SCALE, scales[ph]);
            cfg_write(REG_LENGTH, lens[ph]);
            if (ph == 3) begin
                cfg_write(2'd2, 16'($urandom));
                cfg_write(2'd3, 16'($urandom));
            end
            steady = (ph == 4);
            if (ph == 2) begin
                push_compute(12'd0);
                push_compute(12'd4095);
            end
            random_phase(110);
            wait_idle();
        end
        steady = 1'b0;

        $display("covered %0d loads, %0d computes, %0d results, %0d register writes",
                 n_loads, n_computes, n_results, n_cfg);
        $display("settings swept: scale 0..65535 incl. clamped low scales, length 0..8191");
        if (error_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", error_cnt);
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial begin
        #120_000_000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule
